@@ rtl/cclf_pkg.sv @@
// Shared types, constants and defaults of the column compare line filter.
`timescale 1ns / 1ps
package cclf_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_COLUMNS_DEF = 256;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int COL_W   = 8;
	localparam int OP_W    = 3;
	localparam int OUT_W   = 32;

	// Register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_FIRST_COLUMN  = 2'd0;
	localparam logic [1:0] REG_SECOND_COLUMN = 2'd1;
	localparam logic [1:0] REG_COMPARE_OP    = 2'd2;

	// Comparison operators
	localparam logic [OP_W-1:0] OP_LT = 3'd0;
	localparam logic [OP_W-1:0] OP_GT = 3'd1;
	localparam logic [OP_W-1:0] OP_GE = 3'd2;
	localparam logic [OP_W-1:0] OP_LE = 3'd3;
	localparam logic [OP_W-1:0] OP_EQ = 3'd4;
	localparam logic [OP_W-1:0] OP_NE = 3'd5;

	// Characters of interest
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	typedef struct packed {
		logic [COL_W-1:0] first_column;
		logic [COL_W-1:0] second_column;
		logic [OP_W-1:0]  compare_op;
	} cfg_t;

	typedef enum logic [3:0] {
		PH_SKIP   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

endpackage

@@ rtl/column_compare_line_filter.sv @@
// Top level of the column compare line filter: input and output registers, handshakes.
//
// Text lines arrive on the s_axis channel, one byte per item, with s_axis_tlast set on
// the final byte of each line. Colons split a line into columns; two columns chosen
// through the APB-style port are read as decimal integers (leading blanks, optional
// sign, digits, saturating) and compared by the chosen operator.
// For every line of two or more bytes one result item leaves on m_axis: tuser carries
// the verdict, tdata the two values. One-byte lines give no result.
// An input item is parsed while it sits in the input register, and its result is written
// to the output register when the parser advances, which raises m_axis_tvalid. One byte is
// taken every cycle while the receiver keeps up; the rate is set by the single
// input-to-output pass of the parser.
// When the receiver stalls, the result waits in the output register and the input
// register still takes one more byte; after that s_axis_tready falls until the
// result is taken.
// Reset clears both registers' valid flags, the line state and the configuration
// (first column 0, second column 1, operator less-than). Configuration may only be
// written while no line is in flight.
`timescale 1ns / 1ps
module column_compare_line_filter #(
	parameter int VALUE_WIDTH = cclf_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_COLUMNS = cclf_pkg::MAX_COLUMNS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cclf_pkg::PADDR_W-1:0] paddr,
	input  logic [cclf_pkg::PDATA_W-1:0] pwdata,
	output logic [cclf_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
	input  logic                         s_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [63:0]                  m_axis_tdata,  // [31:0] left_value, [63:32] right_value
	output logic                         m_axis_tuser   // [0] keep_line
);
	import cclf_pkg::*;

	cfg_t cfg;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic                   adv;
	logic                   proc;
	logic                   res_valid;
	logic [VALUE_WIDTH-1:0] res_left, res_right;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] left_q, right_q;
	logic                   keep;

	cclf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The parser advances whenever the output register is free or being emptied.
	assign adv           = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	cclf_parse #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_en     (proc),
		.data_byte   (byte_s1),
		.end_of_line (last_s1),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res_left    (res_left),
		.res_right   (res_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			left_q  <= res_left;
			right_q <= res_right;
		end
	end

	cclf_cmp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_cmp (
		.compare_op  (cfg.compare_op),
		.left_value  (left_q),
		.right_value (right_q),
		.keep_line   (keep)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = keep;
	assign m_axis_tdata  = {OUT_W'($signed(right_q)), OUT_W'($signed(left_q))};

endmodule

@@ rtl/cclf_regs.sv @@
// Configuration registers of the column compare line filter behind an APB-style port.
`timescale 1ns / 1ps
module cclf_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [cclf_pkg::PADDR_W-1:0] paddr,
	input  logic [cclf_pkg::PDATA_W-1:0] pwdata,
	output logic [cclf_pkg::PDATA_W-1:0] prdata,
	output logic                     pready,
	output cclf_pkg::cfg_t           cfg
);
	import cclf_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_column  <= COL_W'(0);
			cfg_q.second_column <= COL_W'(1);
			cfg_q.compare_op    <= OP_LT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FIRST_COLUMN:  cfg_q.first_column  <= pwdata[COL_W-1:0];
				REG_SECOND_COLUMN: cfg_q.second_column <= pwdata[COL_W-1:0];
				REG_COMPARE_OP:    cfg_q.compare_op    <= pwdata[OP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FIRST_COLUMN:  prdata = PDATA_W'(cfg_q.first_column);
			REG_SECOND_COLUMN: prdata = PDATA_W'(cfg_q.second_column);
			REG_COMPARE_OP:    prdata = PDATA_W'(cfg_q.compare_op);
			default:           prdata = '0;
		endcase
	end

endmodule

@@ rtl/cclf_parse.sv @@
// Per-byte column splitter and atoi-style integer parser with line state.
`timescale 1ns / 1ps
module cclf_parse #(
	parameter int VALUE_WIDTH = cclf_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_COLUMNS = cclf_pkg::MAX_COLUMNS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_en,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_line,
	input  cclf_pkg::cfg_t         cfg,
	output logic                   res_valid,
	output logic [VALUE_WIDTH-1:0] res_left,
	output logic [VALUE_WIDTH-1:0] res_right
);
	import cclf_pkg::*;

	localparam int W    = VALUE_WIDTH;
	localparam int COLW = $clog2(MAX_COLUMNS + 1);
	localparam int CMPW = (COLW > COL_W) ? COLW : COL_W;
	localparam logic [W-1:0]    LIM       = W'(1) << (W - 1);
	localparam logic [W-1:0]    LIM_DIV10 = LIM / 10;
	localparam logic [COLW-1:0] COL_MAX   = COLW'(MAX_COLUMNS);

	logic [COLW-1:0] col_q;
	phase_t          phase_q;
	logic            neg_q;
	logic [W-1:0]    mag_q;
	logic [W-1:0]    left_q;
	logic [W-1:0]    right_q;
	logic [1:0]      len_q;

	logic         is_colon, is_digit, is_blank;
	logic [W+3:0] mag_x10;
	logic [W-1:0] mag_dig;
	phase_t       phase_c;
	logic         neg_c;
	logic [W-1:0] mag_c;
	logic         cl_neg;
	logic [W-1:0] cl_mag;
	logic [W-1:0] field_val;
	logic         col_hit;
	logic [W-1:0] left_n, right_n;

	assign is_colon = (data_byte == CH_COLON);
	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_blank = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));

	// Accumulate one decimal digit, clamping the magnitude at the negative limit.
	always_comb begin
		mag_x10 = ((W+4)'(mag_q) << 3) + ((W+4)'(mag_q) << 1) + (W+4)'(data_byte[3:0]);
		if (mag_q > LIM_DIV10) begin
			mag_dig = LIM;
		end else if (mag_x10 > (W+4)'(LIM)) begin
			mag_dig = LIM;
		end else begin
			mag_dig = mag_x10[W-1:0];
		end
	end

	always_comb begin
		phase_c = phase_q;
		neg_c   = neg_q;
		mag_c   = mag_q;
		unique case (phase_q)
			PH_SKIP: begin
				if (is_blank) begin
					phase_c = PH_SKIP;
				end else if (data_byte == CH_PLUS || data_byte == CH_MINUS) begin
					neg_c   = (data_byte == CH_MINUS);
					phase_c = PH_SIGN;
				end else if (is_digit) begin
					mag_c   = mag_dig;
					phase_c = PH_DIGITS;
				end else begin
					phase_c = PH_DONE;
				end
			end
			PH_SIGN, PH_DIGITS: begin
				if (is_digit) begin
					mag_c   = mag_dig;
					phase_c = PH_DIGITS;
				end else begin
					phase_c = PH_DONE;
				end
			end
			PH_DONE: phase_c = PH_DONE;
			default: phase_c = PH_SKIP;
		endcase
	end

	// A colon closes the column as it stands; a final byte that is no colon is
	// parsed first. A colon on the final byte leaves only an empty column behind,
	// which cannot change a capture, so one close covers both cases.
	always_comb begin
		cl_neg = is_colon ? neg_q : neg_c;
		cl_mag = is_colon ? mag_q : mag_c;
		if (cl_neg) begin
			field_val = W'(0) - cl_mag;
		end else if (cl_mag >= LIM) begin
			field_val = LIM - W'(1);
		end else begin
			field_val = cl_mag;
		end
		col_hit = (col_q < COL_MAX);
		left_n  = left_q;
		right_n = right_q;
		if ((is_colon || end_of_line) && col_hit) begin
			if (CMPW'(col_q) == CMPW'(cfg.first_column)) begin
				left_n = field_val;
			end
			if (CMPW'(col_q) == CMPW'(cfg.second_column)) begin
				right_n = field_val;
			end
		end
	end

	assign res_valid = item_en && end_of_line && (len_q != 2'd0);
	assign res_left  = left_n;
	assign res_right = right_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			phase_q <= PH_SKIP;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			left_q  <= '0;
			right_q <= '0;
			len_q   <= '0;
		end else if (item_en) begin
			if (end_of_line) begin
				col_q   <= '0;
				phase_q <= PH_SKIP;
				neg_q   <= 1'b0;
				mag_q   <= '0;
				left_q  <= '0;
				right_q <= '0;
				len_q   <= '0;
			end else begin
				if (len_q != 2'd2) begin
					len_q <= len_q + 2'd1;
				end
				left_q  <= left_n;
				right_q <= right_n;
				if (is_colon) begin
					if (col_hit) begin
						col_q <= col_q + COLW'(1);
					end
					phase_q <= PH_SKIP;
					neg_q   <= 1'b0;
					mag_q   <= '0;
				end else begin
					phase_q <= phase_c;
					neg_q   <= neg_c;
					mag_q   <= mag_c;
				end
			end
		end
	end

	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		item_en && end_of_line |=> col_q == '0 && phase_q == PH_SKIP && len_q == 2'd0)
		else $error("line state not cleared after final item");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_MAX && len_q != 2'd3)
		else $error("column counter or length count out of range");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		item_en && phase_q == PH_DONE && !is_colon && !end_of_line
		|=> $stable(mag_q) && phase_q == PH_DONE)
		else $error("field changed after parsing had ended");

	a_mag_limit: assert property (@(posedge clk) disable iff (!arst_n)
		mag_q <= LIM)
		else $error("magnitude above saturation limit");

endmodule

@@ rtl/cclf_cmp.sv @@
// Signed comparison of the two column values by the configured operator.
`timescale 1ns / 1ps
module cclf_cmp #(
	parameter int VALUE_WIDTH = cclf_pkg::VALUE_WIDTH_DEF
) (
	input  logic [cclf_pkg::OP_W-1:0] compare_op,
	input  logic [VALUE_WIDTH-1:0]    left_value,
	input  logic [VALUE_WIDTH-1:0]    right_value,
	output logic                      keep_line
);
	import cclf_pkg::*;

	logic lt, eq;

	assign lt = $signed(left_value) < $signed(right_value);
	assign eq = (left_value == right_value);

	// Codes beyond the last operator behave as not equal.
	always_comb begin
		case (compare_op)
			OP_LT:   keep_line = lt;
			OP_GT:   keep_line = !lt && !eq;
			OP_GE:   keep_line = !lt;
			OP_LE:   keep_line = lt || eq;
			OP_EQ:   keep_line = eq;
			default: keep_line = !eq;
		endcase
	end

endmodule

@@ tb/sv/tb_column_compare_line_filter.sv @@
// Self-checking testbench of the column compare line filter: directed lines, then random text.
`timescale 1ns / 1ps
module tb_column_compare_line_filter;
	import cclf_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 6;
	localparam int DIR_CASES = 9;
	localparam int PHASES = 9;
	localparam int PHASE_BYTES = 70;
	localparam int SQUEEZE_PHASE = 6;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int COLUMN_SLOTS = 256;

	// Operator codes with no name of their own; the block treats them as not-equal.
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
	localparam logic [7:0] CH_LF = 8'd10;

	typedef struct packed {
		logic               keep;
		logic signed [31:0] left_value;
		logic signed [31:0] right_value;
	} verdict_t;

	typedef struct {
		logic [7:0]      first_col;
		logic [7:0]      second_col;
		logic [OP_W-1:0] op;
		logic [95:0]     text;
		int              len;
		bit              fixed;
		bit              silent;
		verdict_t        want;
	} line_case_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;   // [7:0] data_byte
	logic                s_axis_tlast = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [63:0]         m_axis_tdata;        // [31:0] left_value, [63:32] right_value
	logic                m_axis_tuser;        // [0] keep_line

	column_compare_line_filter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow configuration and line state of the predictor.
	logic [7:0]         cfg_first = 8'd0;
	logic [7:0]         cfg_second = 8'd1;
	logic [OP_W-1:0]    cfg_op = OP_LT;
	int                 col_at;
	phase_t             scan;
	bit                 neg_field;
	logic [31:0]        magnitude;
	logic signed [31:0] left_val;
	logic signed [31:0] right_val;
	int                 bytes_before_end;

	verdict_t   pending_verdicts[$];
	logic [7:0] line_buf[$];
	line_case_t dir_cases[DIR_CASES];
	logic [7:0]      ph_first[PHASES];
	logic [7:0]      ph_second[PHASES];
	logic [OP_W-1:0] ph_op[PHASES];
	bit              ph_long[PHASES];

	int src_idle_pct = 36;
	int dst_idle_pct = 69;
	bit squeeze_req = 1'b0;
	bit squeeze_done = 1'b0;
	int hold_left = 0;
	int mismatches = 0;
	int cycle_count = 0;

	function automatic void clear_field();
		scan = PH_SKIP;
		neg_field = 1'b0;
		magnitude = '0;
	endfunction

	function automatic void restart_line();
		col_at = 0;
		left_val = '0;
		right_val = '0;
		bytes_before_end = 0;
		clear_field();
	endfunction

	// Saturates at 2**31; the positive clamp to the largest value is applied on closing.
	function automatic void add_digit(input logic [7:0] b);
		if (magnitude > 32'd214748364)
			magnitude = 32'h8000_0000;
		else begin
			magnitude = magnitude * 10 + (b - CH_ZERO);
			if (magnitude > 32'h8000_0000)
				magnitude = 32'h8000_0000;
		end
	endfunction

	function automatic void end_column();
		logic signed [31:0] v;
		if (neg_field)
			v = -magnitude;
		else
			v = (magnitude >= 32'h8000_0000) ? 32'h7fff_ffff : magnitude;
		if (col_at < COLUMN_SLOTS) begin
			if (col_at == cfg_first)
				left_val = v;
			if (col_at == cfg_second)
				right_val = v;
			col_at++;
		end
		clear_field();
	endfunction

	function automatic void scan_char(input logic [7:0] b);
		bit digit;
		bit blank;
		digit = b >= CH_ZERO && b <= CH_NINE;
		blank = b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
		case (scan)
			PH_SKIP: begin
				if (blank) begin
				end else if (b == CH_PLUS || b == CH_MINUS) begin
					neg_field = b == CH_MINUS;
					scan = PH_SIGN;
				end else if (digit) begin
					add_digit(b);
					scan = PH_DIGITS;
				end else
					scan = PH_DONE;
			end
			PH_SIGN, PH_DIGITS: begin
				if (digit) begin
					add_digit(b);
					scan = PH_DIGITS;
				end else
					scan = PH_DONE;
			end
			default: ;
		endcase
	endfunction

	function automatic bit line_verdict(input logic [7:0] b, input logic eol,
			output verdict_t v);
		v = '0;
		if (b == CH_COLON)
			end_column();
		else
			scan_char(b);
		if (!eol) begin
			if (bytes_before_end < 2)
				bytes_before_end++;
			return 1'b0;
		end
		end_column();
		if (bytes_before_end == 0) begin
			restart_line();
			return 1'b0;
		end
		v.left_value = left_val;
		v.right_value = right_val;
		case (cfg_op)
			OP_LT: v.keep = left_val < right_val;
			OP_GT: v.keep = left_val > right_val;
			OP_GE: v.keep = left_val >= right_val;
			OP_LE: v.keep = left_val <= right_val;
			OP_EQ: v.keep = left_val == right_val;
			default: v.keep = left_val != right_val;
		endcase
		restart_line();
		return 1'b1;
	endfunction

	// One column's text: optional blanks and sign, digits (some near or past the limit), junk.
	function automatic void add_field();
		string lim_digits = "214748364";
		int r;
		int n;
		logic [7:0] junk;
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				r = $urandom_range(0, 5);
				line_buf.push_back(r == 0 ? CH_SPACE : 8'(CH_TAB + r - 1));
			end
		end
		r = $urandom_range(0, 99);
		if (r < 25)
			line_buf.push_back(CH_MINUS);
		else if (r < 35)
			line_buf.push_back(CH_PLUS);
		n = 0;
		r = $urandom_range(0, 99);
		if (r < 6)
			n = 0;
		else if (r < 12) begin
			for (int i = 0; i < lim_digits.len(); i++)
				line_buf.push_back(lim_digits[i]);
			line_buf.push_back(8'(CH_ZERO + $urandom_range(6, 9)));
		end else if (r < 22)
			n = $urandom_range(10, 12);
		else
			n = $urandom_range(1, 6);
		repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		if ($urandom_range(0, 4) == 0) begin
			do junk = 8'($urandom_range(0, 255)); while (junk == CH_COLON);
			line_buf.push_back(junk);
		end
	endfunction

	function automatic void build_line(input bit long_line);
		int r;
		int ncol;
		line_buf.delete();
		if (long_line) begin
			// Mostly runs past the last column slot; a chosen column that the line reaches always gets a field.
			ncol = $urandom_range(254, 262);
			for (int k = 0; k < ncol; k++) begin
				if (k == cfg_first || k == cfg_second || k >= COLUMN_SLOTS
						|| $urandom_range(0, 19) == 0)
					add_field();
				if (k < ncol - 1)
					line_buf.push_back(CH_COLON);
			end
			line_buf.push_back(CH_LF);
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 6) begin
			line_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if (r < 16) begin
			repeat ($urandom_range(2, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		ncol = $urandom_range(1, 6);
		for (int k = 0; k < ncol; k++) begin
			add_field();
			if (k < ncol - 1)
				line_buf.push_back(CH_COLON);
		end
		r = $urandom_range(0, 9);
		if (r == 0)
			line_buf.push_back(CH_COLON);
		else if (r > 2 || line_buf.size() == 0)
			line_buf.push_back(CH_LF);
	endfunction

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [7:0] fc, input logic [7:0] sc,
			input logic [OP_W-1:0] op);
		reg_write(REG_FIRST_COLUMN, {24'd0, fc});
		reg_write(REG_SECOND_COLUMN, {24'd0, sc});
		reg_write(REG_COMPARE_OP, {29'd0, op});
		cfg_first = fc;
		cfg_second = sc;
		cfg_op = op;
	endtask

	// Idle for the register port: every verdict in, and time for a silent one-byte line.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic eol);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eol;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_line(input bit fixed, input bit silent, input verdict_t want);
		verdict_t v;
		bit got;
		bit eol;
		for (int i = 0; i < line_buf.size(); i++) begin
			eol = i == line_buf.size() - 1;
			push_byte(line_buf[i], eol);
			got = line_verdict(line_buf[i], eol, v);
			if (fixed) begin
				if (eol && !silent)
					pending_verdicts.push_back(want);
			end else if (got)
				pending_verdicts.push_back(v);
		end
	endtask

	// Receiver: random stalls, one long hold-off, and the comparison of every verdict.
	always @(posedge clk) begin
		verdict_t exp_v;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict keep=%0d left=%0d right=%0d", $time,
					m_axis_tuser, $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]));
				mismatches++;
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (m_axis_tuser !== exp_v.keep || m_axis_tdata[31:0] !== exp_v.left_value
						|| m_axis_tdata[63:32] !== exp_v.right_value) begin
					$display({"%0t: expected keep=%0d left=%0d right=%0d,",
						" got keep=%0d left=%0d right=%0d"},
						$time, exp_v.keep, exp_v.left_value, exp_v.right_value, m_axis_tuser,
						$signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]));
					mismatches++;
				end
			end
		end
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (squeeze_req && !squeeze_done) begin
			m_axis_tready <= 1'b0;
			hold_left <= SQUEEZE_CYCLES;
			squeeze_done <= 1'b1;
		end else
			m_axis_tready <= $urandom_range(0, 99) >= dst_idle_pct;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_column_compare_line_filter: done, errors");
			$finish;
		end
	end

	initial begin
		int sent;
		dir_cases[0] = '{8'd0, 8'd1, OP_LT, "\n", 1, 1'b1, 1'b1, '{1'b0, 32'sd0, 32'sd0}};
		dir_cases[1] = '{8'd0, 8'd1, OP_LT, "3:7", 3, 1'b1, 1'b0, '{1'b1, 32'sd3, 32'sd7}};
		// Blank then a lone minus; a plus with no digits.
		dir_cases[2] = '{8'd0, 8'd1, OP_GT, "\t-:+\n", 5, 1'b1, 1'b0,
			'{1'b0, 32'sd0, 32'sd0}};
		// Positive overflow, and a colon as the final byte leaving an empty last column.
		dir_cases[3] = '{8'd0, 8'd1, OP_GE, "3000000000:", 11, 1'b1, 1'b0,
			'{1'b1, 32'h7fff_ffff, 32'sd0}};
		// Negative overflow, both values from the same column.
		dir_cases[4] = '{8'd0, 8'd0, OP_EQ, "-3000000000", 11, 1'b1, 1'b0,
			'{1'b1, 32'h8000_0000, 32'h8000_0000}};
		// The left column is missing; the byte of all ones stops the digits.
		dir_cases[5] = '{8'd2, 8'd0, OP_NE, "5\377", 2, 1'b1, 1'b0,
			'{1'b1, 32'sd0, 32'sd5}};
		dir_cases[6] = '{8'd0, 8'd1, OP_RSVD6, "\000:4", 3, 1'b1, 1'b0,
			'{1'b1, 32'sd0, 32'sd4}};
		dir_cases[7] = '{8'd0, 8'd1, OP_RSVD7, "+1:1", 4, 1'b0, 1'b0, '0};
		dir_cases[8] = '{8'd255, 8'd255, OP_LE, ":\n", 2, 1'b0, 1'b0, '0};

		ph_first = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd0, 8'd3, 8'd1, 8'd255, 8'd0};
		ph_second = '{8'd1, 8'd0, 8'd2, 8'd0, 8'd255, 8'd1, 8'd4, 8'd255, 8'd0};
		ph_op = '{OP_LT, OP_GT, OP_GE, OP_LE, OP_EQ, OP_NE, OP_RSVD6, OP_RSVD7, OP_LT};
		ph_long = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
		ph_first[PHASES-1] = 8'($urandom_range(0, 3));
		ph_second[PHASES-1] = 8'($urandom_range(0, 3));
		ph_op[PHASES-1] = 3'($urandom_range(0, 7));

		restart_line();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_CASES; r++) begin
			if (dir_cases[r].first_col !== cfg_first || dir_cases[r].second_col !== cfg_second
					|| dir_cases[r].op !== cfg_op) begin
				wait_idle();
				apply_config(dir_cases[r].first_col, dir_cases[r].second_col, dir_cases[r].op);
			end
			line_buf.delete();
			for (int i = 0; i < dir_cases[r].len; i++)
				line_buf.push_back(dir_cases[r].text[8*(dir_cases[r].len-1-i) +: 8]);
			send_line(dir_cases[r].fixed, dir_cases[r].silent, dir_cases[r].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			if (p < 3) begin
				src_idle_pct = 36;
				dst_idle_pct = 69;
			end else if (p < 6) begin
				src_idle_pct = 69;
				dst_idle_pct = 36;
			end else begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			apply_config(ph_first[p], ph_second[p], ph_op[p]);
			if (p == SQUEEZE_PHASE)
				squeeze_req <= 1'b1;
			sent = 0;
			if (ph_long[p]) begin
				build_line(1'b1);
				sent += line_buf.size();
				send_line(1'b0, 1'b0, '0);
			end
			while (sent < PHASE_BYTES) begin
				build_line(1'b0);
				sent += line_buf.size();
				send_line(1'b0, 1'b0, '0);
			end
		end

		wait_idle();
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("tb_column_compare_line_filter: done, clean");
		else
			$display("tb_column_compare_line_filter: done, errors");
		$finish;
	end

endmodule
